// File: design/bmhpq_pkg.sv
package bmhpq_pkg;

	localparam int DEPTH      = 64;
	localparam int KEY_BITS   = 8;
	localparam int TAG_BITS   = 16;
	localparam int IDX_BITS   = $clog2(DEPTH);
	localparam int CNT_BITS   = 7;
	localparam int CHILD_BITS = IDX_BITS + 2;
	localparam int ENTRY_BITS = KEY_BITS + TAG_BITS;

	localparam logic [CNT_BITS-1:0] LIMIT_RESET = CNT_BITS'(64);
	localparam logic [CNT_BITS-1:0] LIMIT_MAX   = CNT_BITS'(DEPTH);

	typedef enum logic [1:0] {
		KIND_PUSH   = 2'd0,
		KIND_POP    = 2'd1,
		KIND_REMOVE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [TAG_BITS-1:0] tag;
	} entry_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic [KEY_BITS-1:0] key;
		logic [TAG_BITS-1:0] tag;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [KEY_BITS-1:0] out_key;
		logic [TAG_BITS-1:0] out_tag;
		logic [CNT_BITS-1:0] count;
		logic [KEY_BITS-1:0] top_key;
		logic [TAG_BITS-1:0] top_tag;
	} res_t;

	typedef struct packed {
		logic                we;
		logic [IDX_BITS-1:0] waddr;
		entry_t              wdata;
		logic                re;
		logic [IDX_BITS-1:0] raddr;
	} mem_req_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_LAST,
		S_DN_REQ,
		S_DN_L,
		S_DN_R,
		S_UP_REQ,
		S_UP_CMP,
		S_DONE
	} state_t;

endpackage

// File: design/binary_max_heap_priority_queue.sv
// Push climbs the new entry; pop descends from the root; remove first scans the tags,
// then goes on as pop, with the climb of push when the filler stays put. Nothing moves
// when the heap is full or empty, no tag matches or the last entry is taken. One
// request at a time: busy falls as done rises and a new request may be taken in the
// strobe cycle. Results cannot be held off. Reset empties the heap, limit 64.
module binary_max_heap_priority_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  bmhpq_pkg::req_t                req,
	output logic                           done,
	output bmhpq_pkg::res_t                res,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bmhpq_pkg::CNT_BITS-1:0] cfg_data
);
	import bmhpq_pkg::*;

	logic [CNT_BITS-1:0] limit_q, limit_eff;
	mem_req_t            mreq;
	entry_t              rdata;
	logic [ENTRY_BITS-1:0] rdata_raw;
	logic                ctrl_done;
	res_t                ctrl_res;

	assign cfg_ready = !busy;
	assign limit_eff = (limit_q > LIMIT_MAX) ? LIMIT_MAX : limit_q;
	assign rdata     = entry_t'(rdata_raw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			done    <= 1'b0;
		end else begin
			done <= ctrl_done;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_done) begin
			res <= ctrl_res;
		end
	end

	bmhpq_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mreq.we),
		.waddr(mreq.waddr),
		.wdata(mreq.wdata),
		.re   (mreq.re),
		.raddr(mreq.raddr),
		.rdata(rdata_raw)
	);

	bmhpq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.limit (limit_eff),
		.mreq  (mreq),
		.rdata (rdata),
		.done  (ctrl_done),
		.res   (ctrl_res)
	);

endmodule

// File: design/bmhpq_ram.sv
module bmhpq_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/bmhpq_ctrl.sv
module bmhpq_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  bmhpq_pkg::req_t               req,
	input  logic [bmhpq_pkg::CNT_BITS-1:0] limit,
	output bmhpq_pkg::mem_req_t           mreq,
	input  bmhpq_pkg::entry_t             rdata,
	output logic                          done,
	output bmhpq_pkg::res_t               res
);
	import bmhpq_pkg::*;

	state_t              state_q, state_d;
	logic [CNT_BITS-1:0] cnt_q;
	logic [CNT_BITS-1:0] scan_q;
	logic                chk_vld_q;
	logic [IDX_BITS-1:0] chk_idx_q;
	logic [IDX_BITS-1:0] pos_q;
	entry_t              mov_q, left_q, out_q, root_q;
	logic                moved_q;
	status_t             stat_q;
	logic [TAG_BITS-1:0] tag_q;

	logic                  accept, full, match, last_chk, scan_rd;
	logic [CNT_BITS-1:0]   cnt_dec;
	logic [CHILD_BITS-1:0] l_idx, r_idx, cnt_ext;
	logic                  has_l, has_r, rd_gt, up_gt, dn_take_l, dn_take_r, dn_move;
	entry_t                dn_best, dn_child;
	logic [IDX_BITS-1:0]   dn_child_idx, parent;
	state_t                finish_state;

	always_comb begin
		accept       = start && (state_q == S_IDLE);
		full         = cnt_q >= limit;
		cnt_dec      = cnt_q - CNT_BITS'(1);
		match        = chk_vld_q && (rdata.tag == tag_q);
		last_chk     = chk_vld_q && (CNT_BITS'(chk_idx_q) == cnt_dec);
		scan_rd      = scan_q < cnt_q;
		l_idx        = {1'b0, pos_q, 1'b1};
		r_idx        = {CHILD_BITS'({1'b0, pos_q} + (IDX_BITS+1)'(1))} << 1;
		cnt_ext      = CHILD_BITS'(cnt_q);
		has_l        = l_idx < cnt_ext;
		has_r        = r_idx < cnt_ext;
		rd_gt        = rdata.key > mov_q.key;
		up_gt        = mov_q.key > rdata.key;
		dn_take_l    = left_q.key > mov_q.key;
		dn_best      = dn_take_l ? left_q : mov_q;
		dn_take_r    = rdata.key > dn_best.key;
		dn_move      = dn_take_l || dn_take_r;
		dn_child     = dn_take_r ? rdata : left_q;
		dn_child_idx = dn_take_r ? r_idx[IDX_BITS-1:0] : l_idx[IDX_BITS-1:0];
		parent       = (pos_q - IDX_BITS'(1)) >> 1;
		finish_state = moved_q ? S_DONE : S_UP_REQ;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (req.kind)
						KIND_PUSH:   state_d = full ? S_DONE : S_UP_REQ;
						KIND_POP:    state_d = (cnt_q > CNT_BITS'(1)) ? S_LAST : S_DONE;
						KIND_REMOVE: state_d = (cnt_q == '0) ? S_DONE : S_SCAN;
						default:     state_d = S_DONE;
					endcase
				end
			end
			S_SCAN: begin
				if (match) begin
					state_d = (CNT_BITS'(chk_idx_q) == cnt_dec) ? S_DONE : S_LAST;
				end else if (last_chk) begin
					state_d = S_DONE;
				end
			end
			S_LAST:   state_d = S_DN_REQ;
			S_DN_REQ: state_d = has_l ? S_DN_L : finish_state;
			S_DN_L: begin
				if (has_r) begin
					state_d = S_DN_R;
				end else begin
					state_d = rd_gt ? S_DN_REQ : finish_state;
				end
			end
			S_DN_R:   state_d = dn_move ? S_DN_REQ : finish_state;
			S_UP_REQ: state_d = (pos_q == '0) ? S_DONE : S_UP_CMP;
			S_UP_CMP: state_d = up_gt ? S_UP_REQ : S_DONE;
			S_DONE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// memory requests and strobe
	always_comb begin
		mreq = '0;
		done = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (req.kind == KIND_POP) && (cnt_q > CNT_BITS'(1))) begin
					mreq.re    = 1'b1;
					mreq.raddr = cnt_dec[IDX_BITS-1:0];
				end
			end
			S_SCAN: begin
				if (match) begin
					mreq.re    = CNT_BITS'(chk_idx_q) != cnt_dec;
					mreq.raddr = cnt_dec[IDX_BITS-1:0];
				end else if (!last_chk) begin
					mreq.re    = scan_rd;
					mreq.raddr = scan_q[IDX_BITS-1:0];
				end
			end
			S_DN_REQ: begin
				if (has_l) begin
					mreq.re    = 1'b1;
					mreq.raddr = l_idx[IDX_BITS-1:0];
				end else begin
					mreq.we    = moved_q;
					mreq.waddr = pos_q;
					mreq.wdata = mov_q;
				end
			end
			S_DN_L: begin
				if (has_r) begin
					mreq.re    = 1'b1;
					mreq.raddr = r_idx[IDX_BITS-1:0];
				end else if (rd_gt) begin
					mreq.we    = 1'b1;
					mreq.waddr = pos_q;
					mreq.wdata = rdata;
				end else begin
					mreq.we    = moved_q;
					mreq.waddr = pos_q;
					mreq.wdata = mov_q;
				end
			end
			S_DN_R: begin
				mreq.we    = dn_move || moved_q;
				mreq.waddr = pos_q;
				mreq.wdata = dn_move ? dn_child : mov_q;
			end
			S_UP_REQ: begin
				if (pos_q == '0) begin
					mreq.we    = 1'b1;
					mreq.waddr = '0;
					mreq.wdata = mov_q;
				end else begin
					mreq.re    = 1'b1;
					mreq.raddr = parent;
				end
			end
			S_UP_CMP: begin
				mreq.we    = 1'b1;
				mreq.waddr = pos_q;
				mreq.wdata = up_gt ? rdata : mov_q;
			end
			S_DONE:  done = 1'b1;
			default: mreq = '0;
		endcase
	end

	always_comb begin
		busy        = state_q != S_IDLE;
		res.status  = stat_q;
		res.out_key = out_q.key;
		res.out_tag = out_q.tag;
		res.count   = cnt_q;
		res.top_key = (cnt_q != '0) ? root_q.key : '0;
		res.top_tag = (cnt_q != '0) ? root_q.tag : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			scan_q    <= '0;
			chk_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					scan_q    <= '0;
					chk_vld_q <= 1'b0;
					if (accept) begin
						case (req.kind)
							KIND_PUSH: begin
								if (!full) begin
									cnt_q <= cnt_q + CNT_BITS'(1);
								end
							end
							KIND_POP: begin
								if (cnt_q != '0) begin
									cnt_q <= cnt_dec;
								end
							end
							default: cnt_q <= cnt_q;
						endcase
					end
				end
				S_SCAN: begin
					chk_vld_q <= scan_rd;
					scan_q    <= scan_q + CNT_BITS'(scan_rd);
					if (match) begin
						cnt_q <= cnt_dec;
					end
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (mreq.we && (mreq.waddr == '0)) begin
			root_q <= mreq.wdata;
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					stat_q <= ST_OK;
					out_q  <= '0;
					tag_q  <= req.tag;
					case (req.kind)
						KIND_PUSH: begin
							if (full) begin
								stat_q <= ST_FULL;
							end
							mov_q <= '{key: req.key, tag: req.tag};
							pos_q <= cnt_q[IDX_BITS-1:0];
						end
						KIND_POP: begin
							if (cnt_q == '0) begin
								stat_q <= ST_EMPTY;
							end else begin
								out_q <= root_q;
							end
							pos_q <= '0;
						end
						KIND_REMOVE: begin
							if (cnt_q == '0) begin
								stat_q <= ST_NOT_FOUND;
							end
						end
						default: stat_q <= ST_OK;
					endcase
				end
			end
			S_SCAN: begin
				chk_idx_q <= scan_q[IDX_BITS-1:0];
				if (match) begin
					out_q <= rdata;
					pos_q <= chk_idx_q;
				end else if (last_chk) begin
					stat_q <= ST_NOT_FOUND;
				end
			end
			S_LAST: begin
				mov_q   <= rdata;
				moved_q <= 1'b0;
			end
			S_DN_L: begin
				left_q <= rdata;
				if (!has_r && rd_gt) begin
					pos_q   <= l_idx[IDX_BITS-1:0];
					moved_q <= 1'b1;
				end
			end
			S_DN_R: begin
				if (dn_move) begin
					pos_q   <= dn_child_idx;
					moved_q <= 1'b1;
				end
			end
			S_UP_CMP: begin
				if (up_gt) begin
					pos_q <= parent;
				end
			end
			default: pos_q <= pos_q;
		endcase
	end

endmodule

// File: tb/binary_max_heap_priority_queue_tb.sv
module binary_max_heap_priority_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bmhpq_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		req_t          rq;
		logic [6:0]    lim;
		logic          typed;
		res_t          want;
	} row_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	req_t                req;
	logic                done;
	res_t                res;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CNT_BITS-1:0] cfg_data;

	logic [KEY_BITS-1:0] heap_key [DEPTH];
	logic [TAG_BITS-1:0] heap_tag [DEPTH];
	int                  held;
	int                  cap;

	res_t                due_results [$];
	row_t                rows [$];
	int                  faults;
	int                  cycles;
	int                  idle_pct;

	binary_max_heap_priority_queue DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic void swap_slots(input int a, input int b);
		logic [KEY_BITS-1:0] k;
		logic [TAG_BITS-1:0] t;
		k = heap_key[a];
		t = heap_tag[a];
		heap_key[a] = heap_key[b];
		heap_tag[a] = heap_tag[b];
		heap_key[b] = k;
		heap_tag[b] = t;
	endfunction

	function automatic void climb(input int p);
		while (p > 0 && heap_key[p] > heap_key[(p - 1) / 2]) begin
			swap_slots(p, (p - 1) / 2);
			p = (p - 1) / 2;
		end
	endfunction

	// last entry fills the hole, then sinks and climbs
	function automatic void take_out(input int p);
		int  l;
		int  r;
		int  best;
		int  q;
		bit  moving;
		held--;
		if (p < held) begin
			heap_key[p] = heap_key[held];
			heap_tag[p] = heap_tag[held];
			q = p;
			moving = 1'b1;
			while (moving) begin
				l = 2 * q + 1;
				r = 2 * q + 2;
				best = q;
				if (l < held && heap_key[l] > heap_key[best])
					best = l;
				if (r < held && heap_key[r] > heap_key[best])
					best = r;
				if (best == q) begin
					moving = 1'b0;
				end else begin
					swap_slots(q, best);
					q = best;
				end
			end
			climb(q);
		end
	endfunction

	function automatic res_t heap_apply(input req_t r);
		res_t o;
		int   lim;
		int   spot;
		o = '0;
		lim = cap < DEPTH ? cap : DEPTH;
		case (r.kind)
			KIND_PUSH: begin
				if (held >= lim) begin
					o.status = ST_FULL;
				end else begin
					heap_key[held] = r.key;
					heap_tag[held] = r.tag;
					held++;
					climb(held - 1);
				end
			end
			KIND_POP: begin
				if (held == 0) begin
					o.status = ST_EMPTY;
				end else begin
					o.out_key = heap_key[0];
					o.out_tag = heap_tag[0];
					take_out(0);
				end
			end
			KIND_REMOVE: begin
				spot = held;
				for (int i = held - 1; i >= 0; i--)
					if (heap_tag[i] == r.tag)
						spot = i;
				if (spot >= held) begin
					o.status = ST_NOT_FOUND;
				end else begin
					o.out_key = heap_key[spot];
					o.out_tag = heap_tag[spot];
					take_out(spot);
				end
			end
			default: ;
		endcase
		o.count = CNT_BITS'(held);
		o.top_key = held > 0 ? heap_key[0] : '0;
		o.top_tag = held > 0 ? heap_tag[0] : '0;
		return o;
	endfunction

	task automatic issue(input req_t r, input logic typed, input res_t want);
		res_t p;
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		p = heap_apply(r);
		due_results.push_back(typed ? want : p);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 24))
				@(posedge clk);
		end
	endtask

	task automatic set_limit(input int v);
		start <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= CNT_BITS'(v);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cap = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic add_row(input kind_t k, input int key, input int tag, input int lim,
			input logic typed, input status_t st, input int cnt, input int tk, input int tt);
		row_t w;
		w = '0;
		w.rq.kind = k;
		w.rq.key = KEY_BITS'(key);
		w.rq.tag = TAG_BITS'(tag);
		w.lim = 7'(lim);
		w.typed = typed;
		w.want.status = st;
		w.want.count = CNT_BITS'(cnt);
		w.want.top_key = KEY_BITS'(tk);
		w.want.top_tag = TAG_BITS'(tt);
		rows.push_back(w);
	endtask

	task automatic run_block(input int n, input int lim, input int push_pct);
		req_t r;
		int   roll;
		set_limit(lim);
		repeat (n) begin
			roll = $urandom_range(99);
			if (roll < push_pct)
				r.kind = KIND_PUSH;
			else if ($urandom_range(1))
				r.kind = KIND_POP;
			else
				r.kind = KIND_REMOVE;
			case ($urandom_range(3))
				0: r.key = KEY_BITS'($urandom_range(3));
				1: r.key = $urandom_range(1) ? '1 : '0;
				default: r.key = KEY_BITS'($urandom_range(255));
			endcase
			if (r.kind == KIND_REMOVE && held > 0 && $urandom_range(3) != 0)
				r.tag = heap_tag[$urandom_range(held - 1)];
			else if ($urandom_range(2) == 0)
				r.tag = TAG_BITS'($urandom_range(7));
			else
				r.tag = TAG_BITS'($urandom_range(16'hffff));
			issue(r, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** binary_max_heap_priority_queue: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			if (due_results.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected result: status %0d key %h tag %h count %0d top %h/%h",
						res.status, res.out_key, res.out_tag, res.count, res.top_key,
						res.top_tag);
			end else begin
				want = due_results.pop_front();
				if (res.status !== want.status || res.out_key !== want.out_key ||
						res.out_tag !== want.out_tag || res.count !== want.count ||
						res.top_key !== want.top_key || res.top_tag !== want.top_tag) begin
					faults++;
					if (faults <= 10)
						$display("mismatch: exp %0d %h %h %0d %h %h got %0d %h %h %0d %h %h",
							want.status, want.out_key, want.out_tag, want.count,
							want.top_key, want.top_tag, res.status, res.out_key,
							res.out_tag, res.count, res.top_key, res.top_tag);
				end
			end
		end
	end

	initial begin
		row_t w;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		held = 0;
		cap = 64;
		faults = 0;
		cycles = 0;
		idle_pct = 21;

		add_row(KIND_POP,    8'h00, 16'h0000,  0, 1, ST_EMPTY,     0, 8'h00, 16'h0000);
		add_row(KIND_REMOVE, 8'h00, 16'h0000,  0, 1, ST_NOT_FOUND, 0, 8'h00, 16'h0000);
		add_row(KIND_PUSH,   8'hff, 16'hffff,  0, 1, ST_OK,        1, 8'hff, 16'hffff);
		add_row(KIND_PUSH,   8'h00, 16'h0000,  0, 1, ST_OK,        2, 8'hff, 16'hffff);
		add_row(KIND_PUSH,   8'h80, 16'h1234,  0, 0, ST_OK,        0, 0, 0);
		add_row(KIND_PUSH,   8'h80, 16'h4321,  0, 0, ST_OK,        0, 0, 0);
		add_row(KIND_PUSH,   8'h80, 16'h1234,  0, 0, ST_OK,        0, 0, 0);
		add_row(KIND_PUSH,   8'h7f, 16'h00ff,  0, 0, ST_OK,        0, 0, 0);
		add_row(KIND_REMOVE, 8'h00, 16'h1234,  0, 0, ST_OK,        0, 0, 0);
		add_row(KIND_REMOVE, 8'h00, 16'h9999,  0, 0, ST_OK,        0, 0, 0);
		add_row(KIND_REMOVE, 8'h00, 16'h1234,  0, 0, ST_OK,        0, 0, 0);
		add_row(KIND_POP,    8'h00, 16'h0000,  0, 0, ST_OK,        0, 0, 0);
		add_row(KIND_REMOVE, 8'h00, 16'h0000,  0, 0, ST_OK,        0, 0, 0);
		add_row(KIND_POP,    8'h00, 16'h0000,  0, 0, ST_OK,        0, 0, 0);
		add_row(KIND_POP,    8'h00, 16'h0000,  0, 0, ST_OK,        0, 0, 0);
		add_row(KIND_POP,    8'h00, 16'h0000,  0, 1, ST_EMPTY,     0, 8'h00, 16'h0000);
		add_row(KIND_PUSH,   8'h10, 16'haaaa,  1, 1, ST_OK,        1, 8'h10, 16'haaaa);
		add_row(KIND_PUSH,   8'h20, 16'h5555,  0, 1, ST_FULL,      1, 8'h10, 16'haaaa);
		add_row(KIND_REMOVE, 8'h00, 16'h5555,  0, 1, ST_NOT_FOUND, 1, 8'h10, 16'haaaa);
		add_row(KIND_POP,    8'h00, 16'h0000,  0, 0, ST_OK,        0, 0, 0);
		add_row(KIND_PUSH,   8'h01, 16'h8000, 64, 0, ST_OK,        0, 0, 0);
		add_row(KIND_PUSH,   8'h02, 16'h7fff,  0, 0, ST_OK,        0, 0, 0);
		add_row(KIND_POP,    8'h00, 16'h0000,  0, 0, ST_OK,        0, 0, 0);

		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(posedge clk);

		foreach (rows[i]) begin
			w = rows[i];
			if (w.lim != 0)
				set_limit(w.lim);
			issue(w.rq, w.typed, w.want);
		end

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = ph == 0 ? 21 : (ph == 1 ? 60 : 0);
			run_block(108, 64, 70);
			run_block(108, 64, 35);
			run_block(108, 1, 50);
			run_block(108, 2, 55);
			run_block(108, $urandom_range(3, 63), 60);
			run_block(108, 64, 45);
		end

		start <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (200)
			@(posedge clk);

		if (faults == 0 && due_results.size() == 0)
			$display("** binary_max_heap_priority_queue: PASSED **");
		else
			$display("** binary_max_heap_priority_queue: FAILED **");
		$finish;
	end

endmodule
